>>> hw/rtl/attsm_pkg.sv
// ----------------------------------------------------------------------------
// attsm_pkg: shared types and constants for the attitude target smoother
// Sequencer states, lane control bundle, register indexes and fixed defaults.
// ----------------------------------------------------------------------------
package attsm_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL_GAIN,
    ST_ANGLE,
    ST_MUL_RATE,
    ST_FILT,
    ST_MUL_RECIP,
    ST_COMMIT,
    ST_WAIT
  } attsm_state_e;

  typedef struct packed {
    logic         accept;
    logic         preset;
    attsm_state_e state;
  } attsm_ctrl_t;

  localparam int CfgIdxBits = 3;

  localparam logic [CfgIdxBits-1:0] REG_STEP_GAIN       = 3'd0;
  localparam logic [CfgIdxBits-1:0] REG_TILT_STEP_LIMIT = 3'd1;
  localparam logic [CfgIdxBits-1:0] REG_YAW_STEP_LIMIT  = 3'd2;
  localparam logic [CfgIdxBits-1:0] REG_RATE_SCALE      = 3'd3;
  localparam logic [CfgIdxBits-1:0] REG_TILT_RATE_LIMIT = 3'd4;
  localparam logic [CfgIdxBits-1:0] REG_YAW_RATE_LIMIT  = 3'd5;

  localparam logic [15:0] RST_STEP_GAIN       = 16'd4096;
  localparam logic [14:0] RST_TILT_STEP_LIMIT = 15'd104;
  localparam logic [14:0] RST_YAW_STEP_LIMIT  = 15'd52;
  localparam logic [9:0]  RST_RATE_SCALE      = 10'd100;
  localparam logic [14:0] RST_TILT_RATE_LIMIT = 15'd10430;
  localparam logic [14:0] RST_YAW_RATE_LIMIT  = 15'd5215;

  // ceil(2^30 / 10): exact floor division by ten for operands below 2^27
  localparam logic signed [28:0] RECIP_TEN = 29'sd107374183;
  localparam int RecipShift = 30;

endpackage

>>> hw/rtl/attsm_lane.sv
// ----------------------------------------------------------------------------
// attsm_lane: one axis of the smoother
// Slew-limited angle step and filtered rate, sequenced over one shared
// signed multiplier (gain, rate scale, reciprocal of ten).
// ----------------------------------------------------------------------------
module attsm_lane import attsm_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter bit WRAP       = 1'b0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  attsm_ctrl_t        ctrl_i,
  input  logic signed [15:0] wanted_i,
  input  logic [15:0]        gain_i,
  input  logic [14:0]        step_limit_i,
  input  logic [9:0]         rate_scale_i,
  input  logic [14:0]        rate_limit_i,
  output logic [15:0]        angle_o,
  output logic [15:0]        rate_o
);

  localparam int W = ((ANGLE_BITS > 16) ? ANGLE_BITS : 16) + 2;
  localparam logic signed [W-1:0] AMAX = {{(W-ANGLE_BITS+1){1'b0}}, {(ANGLE_BITS-1){1'b1}}};
  localparam logic signed [W-1:0] AMIN = ~AMAX;

  function automatic logic signed [ANGLE_BITS-1:0] fit_angle(input logic signed [W-1:0] v);
    logic signed [W-1:0] r;
    if (WRAP) r = v;
    else if (v > AMAX) r = AMAX;
    else if (v < AMIN) r = AMIN;
    else r = v;
    return r[ANGLE_BITS-1:0];
  endfunction

  logic signed [15:0]           wanted_q;
  logic signed [ANGLE_BITS-1:0] held_q, held_d;
  logic signed [15:0]           rate_q, rate_d;
  logic signed [ANGLE_BITS-1:0] next_q, next_d;
  logic signed [28:0]           op_a_q, op_a_d, op_b_q, op_b_d;
  logic signed [57:0]           prod_q;
  logic                         neg_q, neg_d;

  logic signed [W-1:0]          wanted_w, held_w, pre_w, diff_w, diff_x, lim_w, d_w;
  logic signed [ANGLE_BITS-1:0] diff_a, dlt_a;
  logic signed [15:0]           d16, dlt16, r16;
  logic signed [32:0]           p, p_neg;
  logic [31:0]                  p_abs, p_rnd;
  logic signed [W-1:0]          s_mag_w, s_w, sum_w, next_w, dlt_w, dlt_x;
  logic signed [ANGLE_BITS-1:0] next_a;
  logic signed [26:0]           raw;
  logic signed [29:0]           raw30, old30, num, num_n;
  logic [27:0]                  mag, x;
  logic signed [24:0]           q_w, r_w, rl_w;

  always_comb begin
    wanted_w = W'(wanted_q);
    held_w   = W'(held_q);
    pre_w    = W'(wanted_i);

    diff_w = wanted_w - held_w;
    diff_a = diff_w[ANGLE_BITS-1:0];
    diff_x = WRAP ? W'(diff_a) : diff_w;
    lim_w  = $signed({{(W-15){1'b0}}, step_limit_i});
    if (diff_x > lim_w) d_w = lim_w;
    else if (diff_x < -lim_w) d_w = -lim_w;
    else d_w = diff_x;
    d16 = d_w[15:0];

    p       = prod_q[32:0];
    p_neg   = -p;
    p_abs   = p[32] ? p_neg[31:0] : p[31:0];
    p_rnd   = p_abs + 32'd32768;
    s_mag_w = $signed({{(W-16){1'b0}}, p_rnd[31:16]});
    s_w     = p[32] ? -s_mag_w : s_mag_w;
    sum_w   = held_w + s_w;
    next_a  = fit_angle(sum_w);
    next_w  = W'(next_a);
    dlt_w   = next_w - held_w;
    dlt_a   = dlt_w[ANGLE_BITS-1:0];
    dlt_x   = WRAP ? W'(dlt_a) : dlt_w;
    dlt16   = dlt_x[15:0];

    raw   = prod_q[26:0];
    raw30 = 30'(raw);
    old30 = 30'(rate_q);
    num   = (old30 <<< 3) - old30 + (raw30 <<< 1) + raw30;
    num_n = -num;
    mag   = num[29] ? num_n[27:0] : num[27:0];
    x     = mag + 28'd5;

    q_w  = $signed({1'b0, prod_q[RecipShift+23:RecipShift]});
    r_w  = neg_q ? -q_w : q_w;
    rl_w = $signed({10'b0, rate_limit_i});
    if (r_w > rl_w) r16 = rl_w[15:0];
    else if (r_w < -rl_w) r16 = 16'(-rl_w);
    else r16 = r_w[15:0];

    held_d = held_q;
    rate_d = rate_q;
    next_d = next_q;
    op_a_d = op_a_q;
    op_b_d = op_b_q;
    neg_d  = neg_q;
    if (ctrl_i.accept && ctrl_i.preset) begin
      held_d = fit_angle(pre_w);
      rate_d = '0;
    end
    unique case (ctrl_i.state)
      ST_DIFF: begin
        op_a_d = 29'(d16);
        op_b_d = $signed({13'b0, gain_i});
      end
      ST_ANGLE: begin
        next_d = next_a;
        op_a_d = 29'(dlt16);
        op_b_d = $signed({19'b0, rate_scale_i});
      end
      ST_FILT: begin
        neg_d  = num[29];
        op_a_d = $signed({1'b0, x});
        op_b_d = RECIP_TEN;
      end
      ST_COMMIT: begin
        held_d = next_q;
        rate_d = r16;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      rate_q <= '0;
    end else begin
      held_q <= held_d;
      rate_q <= rate_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) wanted_q <= wanted_i;
    next_q <= next_d;
    op_a_q <= op_a_d;
    op_b_q <= op_b_d;
    neg_q  <= neg_d;
    prod_q <= op_a_q * op_b_q;
  end

  logic signed [W-1:0] held_out;
  assign held_out = W'(held_q);
  assign angle_o  = held_out[15:0];
  assign rate_o   = rate_q;

endmodule

>>> hw/rtl/attsm_merge.sv
// ----------------------------------------------------------------------------
// attsm_merge: result register
// Gathers the three lane results into one output transfer and holds it
// until taken.
// ----------------------------------------------------------------------------
module attsm_merge import attsm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic [2:0][15:0] angle_i,
  input  logic [2:0][15:0] rate_i,
  input  logic             ready_i,
  output logic             valid_o,
  output logic [95:0]      data_o
);

  logic        valid_q, valid_d;
  logic [95:0] data_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) valid_d = 1'b1;
    else if (ready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) data_q <= {rate_i[2], rate_i[1], rate_i[0], angle_i[2], angle_i[1], angle_i[0]};
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> hw/rtl/attitude_target_smoother.sv
// Smoothing step: states DIFF through COMMIT make three passes through each lane's
// one shared multiplier, then WAIT. Preset: the input transfer loads the angles,
// clears the rates and goes to WAIT. WAIT loads the result register when the output
// is free; no input is taken before that. Reset (asynchronous, active low) clears
// targets and rates to zero, loads the register defaults and leaves the block ready.
// ----------------------------------------------------------------------------
// attitude_target_smoother: slew-limited, low-pass attitude target generator
// Three axis lanes run side by side under one sequencer; a result register
// merges their outputs into one transfer.
// ----------------------------------------------------------------------------
module attitude_target_smoother import attsm_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [47:0]           s_axis_tdata,  // roll_wanted, pitch_wanted, yaw_wanted
  input  logic                  s_axis_tuser,  // operation
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [95:0]           m_axis_tdata,  // roll, pitch, yaw targets, then roll,
                                               // pitch, yaw rate targets
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [15:0]           cfg_data_i
);

  logic [15:0] step_gain_q;
  logic [14:0] tilt_step_limit_q, yaw_step_limit_q, tilt_rate_limit_q, yaw_rate_limit_q;
  logic [9:0]  rate_scale_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_gain_q       <= RST_STEP_GAIN;
      tilt_step_limit_q <= RST_TILT_STEP_LIMIT;
      yaw_step_limit_q  <= RST_YAW_STEP_LIMIT;
      rate_scale_q      <= RST_RATE_SCALE;
      tilt_rate_limit_q <= RST_TILT_RATE_LIMIT;
      yaw_rate_limit_q  <= RST_YAW_RATE_LIMIT;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_STEP_GAIN:       step_gain_q       <= cfg_data_i;
        REG_TILT_STEP_LIMIT: tilt_step_limit_q <= cfg_data_i[14:0];
        REG_YAW_STEP_LIMIT:  yaw_step_limit_q  <= cfg_data_i[14:0];
        REG_RATE_SCALE:      rate_scale_q      <= cfg_data_i[9:0];
        REG_TILT_RATE_LIMIT: tilt_rate_limit_q <= cfg_data_i[14:0];
        REG_YAW_RATE_LIMIT:  yaw_rate_limit_q  <= cfg_data_i[14:0];
        default: begin
        end
      endcase
    end
  end

  attsm_state_e state_q, state_d;
  attsm_ctrl_t  ctrl;
  logic         in_xfer, out_free, load;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    load          = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_d = s_axis_tuser ? ST_WAIT : ST_DIFF;
      end
      ST_DIFF:      state_d = ST_MUL_GAIN;
      ST_MUL_GAIN:  state_d = ST_ANGLE;
      ST_ANGLE:     state_d = ST_MUL_RATE;
      ST_MUL_RATE:  state_d = ST_FILT;
      ST_FILT:      state_d = ST_MUL_RECIP;
      ST_MUL_RECIP: state_d = ST_COMMIT;
      ST_COMMIT:    state_d = ST_WAIT;
      ST_WAIT: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  assign ctrl = '{accept: in_xfer, preset: s_axis_tuser, state: state_q};

  logic [2:0][15:0] angle, rate;

  attsm_lane #(.ANGLE_BITS(ANGLE_BITS), .WRAP(1'b0)) u_roll (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .wanted_i(s_axis_tdata[15:0]),
    .gain_i(step_gain_q), .step_limit_i(tilt_step_limit_q), .rate_scale_i(rate_scale_q),
    .rate_limit_i(tilt_rate_limit_q), .angle_o(angle[0]), .rate_o(rate[0])
  );

  attsm_lane #(.ANGLE_BITS(ANGLE_BITS), .WRAP(1'b0)) u_pitch (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .wanted_i(s_axis_tdata[31:16]),
    .gain_i(step_gain_q), .step_limit_i(tilt_step_limit_q), .rate_scale_i(rate_scale_q),
    .rate_limit_i(tilt_rate_limit_q), .angle_o(angle[1]), .rate_o(rate[1])
  );

  attsm_lane #(.ANGLE_BITS(ANGLE_BITS), .WRAP(1'b1)) u_yaw (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .wanted_i(s_axis_tdata[47:32]),
    .gain_i(step_gain_q), .step_limit_i(yaw_step_limit_q), .rate_scale_i(rate_scale_q),
    .rate_limit_i(yaw_rate_limit_q), .angle_o(angle[2]), .rate_o(rate[2])
  );

  attsm_merge u_merge (
    .clk_i, .rst_ni, .load_i(load), .angle_i(angle), .rate_i(rate),
    .ready_i(m_axis_tready), .valid_o(m_axis_tvalid), .data_o(m_axis_tdata)
  );

endmodule

>>> hw/rtl/attsm_checker.sv
// ----------------------------------------------------------------------------
// attsm_checker: port-level checks for the attitude target smoother
// Watches input and output transfers against the one-item-at-a-time sequencing.
// ----------------------------------------------------------------------------
module attsm_checker import attsm_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata
);

  // one item in flight: no back-to-back input transfers
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  // a new result only appears while the input side is closed
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result raised without an item in flight");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // a fresh result after a preset carries zero rates
  a_preset_rates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser && !m_axis_tvalid
      |=> ##1 m_axis_tvalid && (m_axis_tdata[95:48] == 48'd0))
    else $error("preset result with nonzero rates");

endmodule

bind attitude_target_smoother attsm_checker u_attsm_checker (.*);

>>> tb/tb_attitude_target_smoother.sv
// ----------------------------------------------------------------------------
// tb_attitude_target_smoother: self-checking bench for the target smoother
// A directed table runs first, then random phases under changing register
// settings. Each accepted item goes through a local predictor, and each
// result transfer is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module tb_attitude_target_smoother;
  import attsm_pkg::*;

  localparam logic OP_STEP   = 1'b0;
  localparam logic OP_PRESET = 1'b1;

  localparam logic [CfgIdxBits-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxBits-1:0] REG_SPARE_HI = 3'd7;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_CYCLES     = 400;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 125;

  typedef struct packed {
    logic [15:0] yaw_vel;
    logic [15:0] pitch_vel;
    logic [15:0] roll_vel;
    logic [15:0] yaw;
    logic [15:0] pitch;
    logic [15:0] roll;
  } attitude_out_t;

  typedef enum logic {ROW_ITEM, ROW_REGISTER} row_kind_e;

  typedef struct {
    row_kind_e                kind;
    logic                     op;
    logic [15:0]              roll;
    logic [15:0]              pitch;
    logic [15:0]              yaw;
    logic [CfgIdxBits-1:0]    idx;
    logic [15:0]              value;
    bit                       pinned;
    attitude_out_t            pinned_value;
  } table_row_t;

  typedef struct packed {
    logic [CfgIdxBits-1:0] idx;
    logic [15:0]           value;
  } register_write_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [47:0]           s_axis_tdata;   // roll_wanted, pitch_wanted, yaw_wanted
  logic                  s_axis_tuser;   // operation
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [95:0]           m_axis_tdata;   // roll, pitch, yaw, roll rate, pitch rate, yaw rate
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_index_i;
  logic [15:0]           cfg_data_i;

  attitude_target_smoother DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // predictor state and register mirror
  longint roll_now, pitch_now, yaw_now;
  longint roll_vel_now, pitch_vel_now, yaw_vel_now;
  longint gain_cfg, tilt_step_cfg, yaw_step_cfg, scale_cfg, tilt_vlim_cfg, yaw_vlim_cfg;

  attitude_out_t   expected_targets[$];
  table_row_t      stimulus_table[$];
  register_write_t register_writes[$];

  bit            drive_pinned;
  attitude_out_t drive_pinned_value;
  bit            brisk;
  bit            hold_request;
  int            items_sent;
  int            results_seen;
  int            error_count;
  int            step_count;
  int            preset_count;
  int            settings_count;
  int            cycle_count;
  attitude_out_t got_targets;
  attitude_out_t want_targets;

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint round_div(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic longint limit_to(longint v, longint lim);
    if (v < -lim) return -lim;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic longint sat_angle(longint v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  function automatic longint wrap_angle(longint v);
    return $signed(v[15:0]);
  endfunction

  function automatic longint filter_rate(longint old, longint delta, longint lim);
    return limit_to(round_div(7 * old + 3 * delta * scale_cfg, 10), lim);
  endfunction

  function automatic void reset_predictor();
    gain_cfg      = RST_STEP_GAIN;
    tilt_step_cfg = RST_TILT_STEP_LIMIT;
    yaw_step_cfg  = RST_YAW_STEP_LIMIT;
    scale_cfg     = RST_RATE_SCALE;
    tilt_vlim_cfg = RST_TILT_RATE_LIMIT;
    yaw_vlim_cfg  = RST_YAW_RATE_LIMIT;
    roll_now      = 0;
    pitch_now     = 0;
    yaw_now       = 0;
    roll_vel_now  = 0;
    pitch_vel_now = 0;
    yaw_vel_now   = 0;
  endfunction

  function automatic void apply_register(logic [CfgIdxBits-1:0] idx, logic [15:0] value);
    case (idx)
      REG_STEP_GAIN:       gain_cfg      = value;
      REG_TILT_STEP_LIMIT: tilt_step_cfg = value[14:0];
      REG_YAW_STEP_LIMIT:  yaw_step_cfg  = value[14:0];
      REG_RATE_SCALE:      scale_cfg     = value[9:0];
      REG_TILT_RATE_LIMIT: tilt_vlim_cfg = value[14:0];
      REG_YAW_RATE_LIMIT:  yaw_vlim_cfg  = value[14:0];
      default: ;
    endcase
  endfunction

  function automatic attitude_out_t advance_targets(logic op, logic [15:0] r_in,
                                                    logic [15:0] p_in, logic [15:0] y_in);
    longint rw, pw, yw, dr, dp, dy, nr, np, ny;
    attitude_out_t o;
    rw = $signed(r_in);
    pw = $signed(p_in);
    yw = $signed(y_in);
    if (op == OP_PRESET) begin
      roll_now      = sat_angle(rw);
      pitch_now     = sat_angle(pw);
      yaw_now       = wrap_angle(yw);
      roll_vel_now  = 0;
      pitch_vel_now = 0;
      yaw_vel_now   = 0;
    end else begin
      dr = limit_to(rw - roll_now, tilt_step_cfg);
      dp = limit_to(pw - pitch_now, tilt_step_cfg);
      dy = limit_to(wrap_angle(yw - yaw_now), yaw_step_cfg);
      nr = sat_angle(roll_now + round_div(dr * gain_cfg, 65536));
      np = sat_angle(pitch_now + round_div(dp * gain_cfg, 65536));
      ny = wrap_angle(yaw_now + round_div(dy * gain_cfg, 65536));
      roll_vel_now  = filter_rate(roll_vel_now, nr - roll_now, tilt_vlim_cfg);
      pitch_vel_now = filter_rate(pitch_vel_now, np - pitch_now, tilt_vlim_cfg);
      yaw_vel_now   = filter_rate(yaw_vel_now, wrap_angle(ny - yaw_now), yaw_vlim_cfg);
      roll_now  = nr;
      pitch_now = np;
      yaw_now   = ny;
    end
    o.roll      = roll_now[15:0];
    o.pitch     = pitch_now[15:0];
    o.yaw       = yaw_now[15:0];
    o.roll_vel  = roll_vel_now[15:0];
    o.pitch_vel = pitch_vel_now[15:0];
    o.yaw_vel   = yaw_vel_now[15:0];
    return o;
  endfunction

  function automatic attitude_out_t angles_at_rest(logic [15:0] r, logic [15:0] p,
                                                   logic [15:0] y);
    attitude_out_t o;
    o = '0;
    o.roll  = r;
    o.pitch = p;
    o.yaw   = y;
    return o;
  endfunction

  function automatic void row_item(logic op, logic [15:0] r, logic [15:0] p, logic [15:0] y);
    table_row_t row;
    row = '{ROW_ITEM, op, r, p, y, REG_STEP_GAIN, 16'd0, 1'b0, '0};
    stimulus_table.push_back(row);
  endfunction

  function automatic void row_pinned(logic op, logic [15:0] r, logic [15:0] p,
                                     logic [15:0] y, attitude_out_t result);
    table_row_t row;
    row = '{ROW_ITEM, op, r, p, y, REG_STEP_GAIN, 16'd0, 1'b1, result};
    stimulus_table.push_back(row);
  endfunction

  function automatic void row_register(logic [CfgIdxBits-1:0] idx, logic [15:0] value);
    table_row_t row;
    row = '{ROW_REGISTER, OP_STEP, 16'd0, 16'd0, 16'd0, idx, value, 1'b0, '0};
    stimulus_table.push_back(row);
  endfunction

  function automatic int draw_gap();
    return brisk ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic logic [15:0] pick_angle(longint held);
    longint v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 65535);
      4, 5, 6, 7: v = held + longint'($urandom_range(0, 800)) - 400;
      8: begin
        case ($urandom_range(0, 3))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = 16'h0000;
          default: v = 16'hFFFF;
        endcase
      end
      default: v = held + longint'($urandom_range(0, 80)) - 40;
    endcase
    return v[15:0];
  endfunction

  task automatic report_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
               $signed(want), $signed(got));
    end
  endtask

  task automatic send_item(logic op, logic [15:0] r, logic [15:0] p, logic [15:0] y,
                           bit pin, attitude_out_t pin_value);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tuser       <= op;
    s_axis_tdata       <= {y, p, r};
    drive_pinned       <= pin;
    drive_pinned_value <= pin_value;
    s_axis_tvalid      <= 1'b1;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    items_sent++;
    if (op == OP_PRESET) preset_count++;
    else step_count++;
  endtask

  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_registers();
    foreach (register_writes[i]) begin
      cfg_index_i <= register_writes[i].idx;
      cfg_data_i  <= register_writes[i].value;
      cfg_valid_i <= 1'b1;
      do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    end
    cfg_valid_i <= 1'b0;
    register_writes.delete();
    settings_count++;
  endtask

  task automatic queue_write(logic [CfgIdxBits-1:0] idx, logic [15:0] value);
    register_writes.push_back('{idx, value});
  endtask

  // result check, register mirror and prediction share one edge-ordered block
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_targets = m_axis_tdata;
        if (expected_targets.size() == 0) begin
          error_count++;
          $display("%0t: result transfer with nothing expected, expected none, actual %h",
                   $time, m_axis_tdata);
        end else begin
          want_targets = expected_targets.pop_front();
          report_field("roll angle", want_targets.roll, got_targets.roll);
          report_field("pitch angle", want_targets.pitch, got_targets.pitch);
          report_field("yaw angle", want_targets.yaw, got_targets.yaw);
          report_field("roll rate", want_targets.roll_vel, got_targets.roll_vel);
          report_field("pitch rate", want_targets.pitch_vel, got_targets.pitch_vel);
          report_field("yaw rate", want_targets.yaw_vel, got_targets.yaw_vel);
        end
        results_seen++;
      end
      if (cfg_valid_i && cfg_ready_o) apply_register(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) begin
        want_targets = advance_targets(s_axis_tuser, s_axis_tdata[15:0],
                                       s_axis_tdata[31:16], s_axis_tdata[47:32]);
        if (drive_pinned) want_targets = drive_pinned_value;
        expected_targets.push_back(want_targets);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end
      gap = draw_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  initial begin
    logic [15:0] r, p, y;
    logic        op;
    rst_ni             <= 1'b0;
    s_axis_tvalid      <= 1'b0;
    s_axis_tuser       <= OP_STEP;
    s_axis_tdata       <= '0;
    cfg_valid_i        <= 1'b0;
    cfg_index_i        <= REG_STEP_GAIN;
    cfg_data_i         <= '0;
    drive_pinned       <= 1'b0;
    drive_pinned_value <= '0;
    brisk        = 1'b0;
    hold_request = 1'b0;
    items_sent   = 0;
    results_seen = 0;
    error_count  = 0;
    step_count   = 0;
    preset_count = 0;
    settings_count = 0;
    cycle_count  = 0;
    reset_predictor();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    row_pinned(OP_STEP, 16'd0, 16'd0, 16'd0, angles_at_rest(16'd0, 16'd0, 16'd0));
    row_pinned(OP_PRESET, 16'h7FFF, 16'h8000, 16'h8000,
               angles_at_rest(16'h7FFF, 16'h8000, 16'h8000));
    row_pinned(OP_STEP, 16'h7FFF, 16'h8000, 16'h7FFF,
               angles_at_rest(16'h7FFF, 16'h8000, 16'h8000));
    row_item(OP_STEP, 16'h8000, 16'h7FFF, 16'h0000);
    row_item(OP_STEP, 16'h8000, 16'h7FFF, 16'h0000);
    row_pinned(OP_PRESET, 16'd0, 16'd0, 16'd0, angles_at_rest(16'd0, 16'd0, 16'd0));
    row_register(REG_STEP_GAIN, 16'd0);
    row_pinned(OP_STEP, 16'd5000, -16'sd5000, 16'd20000, angles_at_rest(16'd0, 16'd0, 16'd0));
    row_register(REG_STEP_GAIN, 16'hFFFF);
    row_register(REG_TILT_STEP_LIMIT, 16'd0);
    row_register(REG_YAW_STEP_LIMIT, 16'd0);
    row_pinned(OP_STEP, 16'h8000, 16'h7FFF, 16'h8000, angles_at_rest(16'd0, 16'd0, 16'd0));
    row_register(REG_TILT_STEP_LIMIT, 16'h7FFF);
    row_register(REG_YAW_STEP_LIMIT, 16'hFFFF);
    row_item(OP_STEP, 16'd20000, -16'sd20000, 16'd30000);
    row_register(REG_RATE_SCALE, 16'd0);
    row_item(OP_STEP, -16'sd20000, 16'd20000, -16'sd30000);
    row_register(REG_RATE_SCALE, 16'hFFFF);
    row_register(REG_TILT_RATE_LIMIT, 16'd0);
    row_register(REG_YAW_RATE_LIMIT, 16'd0);
    row_item(OP_STEP, 16'd1000, -16'sd1000, 16'd16384);
    row_register(REG_TILT_RATE_LIMIT, 16'h7FFF);
    row_register(REG_YAW_RATE_LIMIT, 16'hFFFF);
    row_item(OP_STEP, 16'h7FFF, 16'h8000, 16'd0);
    row_pinned(OP_PRESET, 16'd100, -16'sd100, 16'd32760,
               angles_at_rest(16'd100, -16'sd100, 16'd32760));
    row_item(OP_STEP, 16'd100, -16'sd100, -16'sd32760);
    row_register(REG_SPARE_LO, 16'hFFFF);
    row_item(OP_STEP, 16'd300, -16'sd300, 16'd100);

    foreach (stimulus_table[i]) begin
      if (stimulus_table[i].kind == ROW_REGISTER) begin
        drain_pipeline();
        queue_write(stimulus_table[i].idx, stimulus_table[i].value);
        program_registers();
      end else begin
        send_item(stimulus_table[i].op, stimulus_table[i].roll, stimulus_table[i].pitch,
                  stimulus_table[i].yaw, stimulus_table[i].pinned,
                  stimulus_table[i].pinned_value);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_pipeline();
      case (phase)
        0: begin
          queue_write(REG_STEP_GAIN, RST_STEP_GAIN);
          queue_write(REG_TILT_STEP_LIMIT, 16'(RST_TILT_STEP_LIMIT));
          queue_write(REG_YAW_STEP_LIMIT, 16'(RST_YAW_STEP_LIMIT));
          queue_write(REG_RATE_SCALE, 16'(RST_RATE_SCALE));
          queue_write(REG_TILT_RATE_LIMIT, 16'(RST_TILT_RATE_LIMIT));
          queue_write(REG_YAW_RATE_LIMIT, 16'(RST_YAW_RATE_LIMIT));
        end
        1: begin
          queue_write(REG_STEP_GAIN, 16'hFFFF);
          queue_write(REG_TILT_STEP_LIMIT, 16'hFFFF);
          queue_write(REG_YAW_STEP_LIMIT, 16'hFFFF);
          queue_write(REG_RATE_SCALE, 16'hFFFF);
          queue_write(REG_TILT_RATE_LIMIT, 16'hFFFF);
          queue_write(REG_YAW_RATE_LIMIT, 16'hFFFF);
        end
        2: begin
          queue_write(REG_STEP_GAIN, 16'd0);
          queue_write(REG_TILT_STEP_LIMIT, 16'd0);
          queue_write(REG_YAW_STEP_LIMIT, 16'd0);
          queue_write(REG_RATE_SCALE, 16'd0);
          queue_write(REG_TILT_RATE_LIMIT, 16'd0);
          queue_write(REG_YAW_RATE_LIMIT, 16'd0);
        end
        3: begin
          queue_write(REG_STEP_GAIN, 16'd1);
          queue_write(REG_TILT_STEP_LIMIT, 16'd1);
          queue_write(REG_YAW_STEP_LIMIT, 16'd1);
          queue_write(REG_RATE_SCALE, 16'd1);
          queue_write(REG_TILT_RATE_LIMIT, 16'd1);
          queue_write(REG_YAW_RATE_LIMIT, 16'd1);
        end
        default: begin
          queue_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                      16'($urandom_range(0, 65535)));
          queue_write(REG_STEP_GAIN, 16'($urandom_range(0, 65535)));
          queue_write(REG_TILT_STEP_LIMIT, 16'($urandom_range(8, 4000)));
          queue_write(REG_YAW_STEP_LIMIT, 16'($urandom_range(8, 4000)));
          queue_write(REG_RATE_SCALE, 16'($urandom_range(1, 1000)));
          queue_write(REG_TILT_RATE_LIMIT, 16'($urandom_range(0, 32767)));
          queue_write(REG_YAW_RATE_LIMIT, 16'($urandom_range(0, 32767)));
        end
      endcase
      program_registers();
      brisk = (phase == 1 || phase == 6);
      if (phase == 4) hold_request = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 5 && n == ITEMS_PER_PHASE / 2) drain_pipeline();
        op = ($urandom_range(0, 11) == 0) ? OP_PRESET : OP_STEP;
        r  = pick_angle(roll_now);
        p  = pick_angle(pitch_now);
        y  = pick_angle(yaw_now);
        send_item(op, r, p, y, 1'b0, '0);
      end
    end

    drain_pipeline();
    if (expected_targets.size() != 0) begin
      error_count++;
      $display("%0t: %0d expected results never arrived", $time, expected_targets.size());
    end
    $display("Ran %0d smoothing steps and %0d presets under %0d register settings,",
             step_count, preset_count, settings_count);
    $display("with %0d result transfers compared and %0d mismatches.",
             results_seen, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/attsm_pkg.sv
hw/rtl/attsm_lane.sv
hw/rtl/attsm_merge.sv
hw/rtl/attitude_target_smoother.sv
hw/rtl/attsm_checker.sv
tb/tb_attitude_target_smoother.sv
